### rtl/ufaf_pkg.sv
// Shared types, register indexes and the saturation helper of the uniform
// field atom force block. No dependencies.
`timescale 1ns / 1ps

package ufaf_pkg;

    typedef logic signed [31:0] t_word;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIPOLE_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POT_ENABLE   = 3'd5;

    localparam logic signed [63:0] WORD_MAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] WORD_MIN64 = 64'shFFFF_FFFF_8000_0000;

    // Clamp a wide signed value into the 32-bit signed range.
    function automatic t_word sat32(input logic signed [63:0] x);
        t_word res;
        if (x > WORD_MAX64) begin
            res = WORD_MAX64[31:0];
        end else if (x < WORD_MIN64) begin
            res = WORD_MIN64[31:0];
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

### rtl/uniform_field_atom_forces_core.sv
// Top level of the uniform field atom force block: sequencer, operand
// selection, accumulation and output register. Depends on ufaf_pkg, ufaf_mul.
`timescale 1ns / 1ps

// Usage:
// Atoms arrive on the input channel (i_in_valid / o_in_ready), one per
// transaction, with position, charges, dipole and flags. Results leave on
// the output channel (o_out_valid / i_out_ready), one per atom, in order.
// Field, scale factors and the per-atom potential enable are written
// through the plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data); the
// user must do so only while the block is idle; the block does not enforce it.
// An index beyond the register list is ignored. One shared multiplier does
// all 25 products of an atom, one issued per cycle. The result is registered
// once the schedule and the states S_LAST, S_FIN1 and S_FIN2 are through; no
// new atom is taken before then, and the next can be taken in the cycle after.
// The two saturating potential-sum additions fall in S_FIN1 and S_FIN2.
// On the last atom of a sweep the sum including that atom is reported
// and the sum clears. If the receiver stalls, the finished atom waits in
// the output register; the next atom is worked on meanwhile but its result
// holds until the register frees. Reset clears the sum, loads the register
// defaults (scales 1.0) and empties the output register.

module uniform_field_atom_forces_core
    import ufaf_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SUM_WIDTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_word                i_pos_x,
    input  t_word                i_pos_y,
    input  t_word                i_pos_z,
    input  t_word                i_fixed_charge,
    input  logic                 i_has_fixed_charge,
    input  t_word                i_fluc_charge,
    input  logic                 i_has_fluc_charge,
    input  t_word                i_dip_x,
    input  t_word                i_dip_y,
    input  t_word                i_dip_z,
    input  logic                 i_has_dipole,
    input  logic                 i_last_atom,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_word                o_force_x,
    output t_word                o_force_y,
    output t_word                o_force_z,
    output t_word                o_torque_x,
    output t_word                o_torque_y,
    output t_word                o_torque_z,
    output t_word                o_fluc_force,
    output t_word                o_atom_pot,
    output logic signed [47:0]   o_total_pot,
    output logic                 o_sweep_done
);

    localparam int ACC_W = 34;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_FIN1 = 3'd3;
    localparam logic [2:0] S_FIN2 = 3'd4;

    // Product schedule, one product issued per step.
    localparam logic [4:0] ST_FE0  = 5'd0;
    localparam logic [4:0] ST_FE1  = 5'd1;
    localparam logic [4:0] ST_FE2  = 5'd2;
    localparam logic [4:0] ST_D0   = 5'd3;
    localparam logic [4:0] ST_D1   = 5'd4;
    localparam logic [4:0] ST_D2   = 5'd5;
    localparam logic [4:0] ST_F0   = 5'd6;
    localparam logic [4:0] ST_F1   = 5'd7;
    localparam logic [4:0] ST_F2   = 5'd8;
    localparam logic [4:0] ST_RE0  = 5'd9;
    localparam logic [4:0] ST_RE1  = 5'd10;
    localparam logic [4:0] ST_RE2  = 5'd11;
    localparam logic [4:0] ST_T0A  = 5'd12;
    localparam logic [4:0] ST_T0B  = 5'd13;
    localparam logic [4:0] ST_T1A  = 5'd14;
    localparam logic [4:0] ST_T1B  = 5'd15;
    localparam logic [4:0] ST_T2A  = 5'd16;
    localparam logic [4:0] ST_T2B  = 5'd17;
    localparam logic [4:0] ST_FQ   = 5'd18;
    localparam logic [4:0] ST_RF0  = 5'd19;
    localparam logic [4:0] ST_RF1  = 5'd20;
    localparam logic [4:0] ST_RF2  = 5'd21;
    localparam logic [4:0] ST_DE0  = 5'd22;
    localparam logic [4:0] ST_DE1  = 5'd23;
    localparam logic [4:0] ST_DE2  = 5'd24;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // configuration registers
    t_word r_field_x, r_field_y, r_field_z;
    t_word r_charge_scale, r_dipole_scale;
    logic  r_pot_enable;

    // control
    logic [2:0] r_state;
    logic [4:0] r_step;
    logic [4:0] r_step_d;
    logic       r_vld_d;

    // captured atom
    t_word r_pos_x, r_pos_y, r_pos_z;
    t_word r_dip_x, r_dip_y, r_dip_z;
    t_word r_q;
    logic  r_fix_on, r_fluc_on, r_dip_on, r_last;

    // intermediates
    t_word r_fe0, r_fe1, r_fe2;
    t_word r_d0, r_d1, r_d2;
    t_word r_f0, r_f1, r_f2;
    t_word r_dot;
    t_word r_t0, r_t1, r_t2;
    t_word r_fq, r_uchg, r_udip;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SUM_WIDTH-1:0] r_sum;

    // output register
    logic  r_out_valid;
    t_word r_force_x, r_force_y, r_force_z;
    t_word r_torque_x, r_torque_y, r_torque_z;
    t_word r_fluc_force, r_atom_pot;
    logic signed [47:0] r_total_pot;
    logic  r_sweep_done;

    logic  in_acc;
    logic  commit;
    logic  charged;
    t_word q_fix, q_in;
    t_word mul_a, mul_b, mul_p;
    logic  mul_en;
    logic signed [ACC_W-1:0] acc_add, acc_sub;
    t_word dot_sat;
    t_word u_chg_m, u_dip_m, sum_u;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_FIN2) && (!r_out_valid || i_out_ready);
    assign charged    = r_fix_on || r_fluc_on;

    // Charge of the atom, formed as it is captured.
    assign q_fix = i_has_fixed_charge ? i_fixed_charge : '0;
    assign q_in  = i_has_fluc_charge ? sat32(64'(q_fix) + 64'(i_fluc_charge)) : q_fix;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_x      <= '0;
            r_field_y      <= '0;
            r_field_z      <= '0;
            r_charge_scale <= 32'sd65536;
            r_dipole_scale <= 32'sd65536;
            r_pot_enable   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FIELD_X:      r_field_x      <= i_cfg_data;
                REG_FIELD_Y:      r_field_y      <= i_cfg_data;
                REG_FIELD_Z:      r_field_z      <= i_cfg_data;
                REG_CHARGE_SCALE: r_charge_scale <= i_cfg_data;
                REG_DIPOLE_SCALE: r_dipole_scale <= i_cfg_data;
                REG_POT_ENABLE:   r_pot_enable   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_FE0;
            r_vld_d <= 1'b0;
        end else begin
            r_vld_d <= (r_state == S_RUN);
            unique case (r_state)
                S_IDLE: begin
                    r_step <= ST_FE0;
                    if (in_acc) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_step == ST_DE2) begin
                        r_state <= S_LAST;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_LAST: r_state <= S_FIN1;
                S_FIN1: r_state <= S_FIN2;
                S_FIN2: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_step_d <= r_step;
        if (in_acc) begin
            r_pos_x   <= i_pos_x;
            r_pos_y   <= i_pos_y;
            r_pos_z   <= i_pos_z;
            r_dip_x   <= i_dip_x;
            r_dip_y   <= i_dip_y;
            r_dip_z   <= i_dip_z;
            r_q       <= q_in;
            r_fix_on  <= i_has_fixed_charge;
            r_fluc_on <= i_has_fluc_charge;
            r_dip_on  <= i_has_dipole;
            r_last    <= i_last_atom;
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        unique case (r_step)
            ST_FE0:  begin mul_a = r_field_x; mul_b = r_q;            end
            ST_FE1:  begin mul_a = r_field_y; mul_b = r_q;            end
            ST_FE2:  begin mul_a = r_field_z; mul_b = r_q;            end
            ST_D0:   begin mul_a = r_dip_x;   mul_b = r_dipole_scale; end
            ST_D1:   begin mul_a = r_dip_y;   mul_b = r_dipole_scale; end
            ST_D2:   begin mul_a = r_dip_z;   mul_b = r_dipole_scale; end
            ST_F0:   begin mul_a = r_fe0;     mul_b = r_charge_scale; end
            ST_F1:   begin mul_a = r_fe1;     mul_b = r_charge_scale; end
            ST_F2:   begin mul_a = r_fe2;     mul_b = r_charge_scale; end
            ST_RE0:  begin mul_a = r_pos_x;   mul_b = r_field_x;      end
            ST_RE1:  begin mul_a = r_pos_y;   mul_b = r_field_y;      end
            ST_RE2:  begin mul_a = r_pos_z;   mul_b = r_field_z;      end
            ST_T0A:  begin mul_a = r_d1;      mul_b = r_field_z;      end
            ST_T0B:  begin mul_a = r_d2;      mul_b = r_field_y;      end
            ST_T1A:  begin mul_a = r_d2;      mul_b = r_field_x;      end
            ST_T1B:  begin mul_a = r_d0;      mul_b = r_field_z;      end
            ST_T2A:  begin mul_a = r_d0;      mul_b = r_field_y;      end
            ST_T2B:  begin mul_a = r_d1;      mul_b = r_field_x;      end
            ST_FQ:   begin mul_a = r_dot;     mul_b = r_charge_scale; end
            ST_RF0:  begin mul_a = r_pos_x;   mul_b = r_f0;           end
            ST_RF1:  begin mul_a = r_pos_y;   mul_b = r_f1;           end
            ST_RF2:  begin mul_a = r_pos_z;   mul_b = r_f2;           end
            ST_DE0:  begin mul_a = r_d0;      mul_b = r_field_x;      end
            ST_DE1:  begin mul_a = r_d1;      mul_b = r_field_y;      end
            ST_DE2:  begin mul_a = r_d2;      mul_b = r_field_z;      end
            default: begin mul_a = '0;        mul_b = '0;             end
        endcase
    end

    assign mul_en = (r_state == S_RUN);

    ufaf_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign acc_add = r_acc + ACC_W'(mul_p);
    assign acc_sub = r_acc - ACC_W'(mul_p);
    assign dot_sat = sat32(64'(acc_add));

    // Second stage: stores or accumulates the saturated product of the step issued in the previous cycle.
    always_ff @(posedge i_clk) begin
        if (r_vld_d) begin
            unique case (r_step_d)
                ST_FE0:  r_fe0  <= mul_p;
                ST_FE1:  r_fe1  <= mul_p;
                ST_FE2:  r_fe2  <= mul_p;
                ST_D0:   r_d0   <= mul_p;
                ST_D1:   r_d1   <= mul_p;
                ST_D2:   r_d2   <= mul_p;
                ST_F0:   r_f0   <= mul_p;
                ST_F1:   r_f1   <= mul_p;
                ST_F2:   r_f2   <= mul_p;
                ST_RE0:  r_acc  <= ACC_W'(mul_p);
                ST_RE1:  r_acc  <= acc_add;
                ST_RE2:  r_dot  <= dot_sat;
                ST_T0A:  r_acc  <= ACC_W'(mul_p);
                ST_T0B:  r_t0   <= sat32(64'(acc_sub));
                ST_T1A:  r_acc  <= ACC_W'(mul_p);
                ST_T1B:  r_t1   <= sat32(64'(acc_sub));
                ST_T2A:  r_acc  <= ACC_W'(mul_p);
                ST_T2B:  r_t2   <= sat32(64'(acc_sub));
                ST_FQ:   r_fq   <= mul_p;
                ST_RF0:  r_acc  <= ACC_W'(mul_p);
                ST_RF1:  r_acc  <= acc_add;
                ST_RF2:  r_uchg <= sat32(-64'(dot_sat));
                ST_DE0:  r_acc  <= ACC_W'(mul_p);
                ST_DE1:  r_acc  <= acc_add;
                ST_DE2:  r_udip <= sat32(-64'(dot_sat));
                default: begin
                end
            endcase
        end
    end

    // One saturating adder serves both potential additions.
    assign u_chg_m  = charged  ? r_uchg : '0;
    assign u_dip_m  = r_dip_on ? r_udip : '0;
    assign sum_u    = (r_state == S_FIN1) ? u_chg_m : u_dip_m;
    assign sum_wide = (SUM_WIDTH+1)'(r_sum) + (SUM_WIDTH+1)'(sum_u);

    always_comb begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_state == S_FIN1) begin
            r_sum <= sum_sat;
        end else if (commit) begin
            r_sum <= r_last ? '0 : sum_sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_force_x    <= charged  ? r_f0 : '0;
            r_force_y    <= charged  ? r_f1 : '0;
            r_force_z    <= charged  ? r_f2 : '0;
            r_torque_x   <= r_dip_on ? r_t0 : '0;
            r_torque_y   <= r_dip_on ? r_t1 : '0;
            r_torque_z   <= r_dip_on ? r_t2 : '0;
            r_fluc_force <= r_fluc_on ? r_fq : '0;
            r_atom_pot   <= r_pot_enable ? sat32(64'(u_chg_m) + 64'(u_dip_m)) : '0;
            r_total_pot  <= r_last ? 48'(64'(sum_sat)) : '0;
            r_sweep_done <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_force_x    = r_force_x;
    assign o_force_y    = r_force_y;
    assign o_force_z    = r_force_z;
    assign o_torque_x   = r_torque_x;
    assign o_torque_y   = r_torque_y;
    assign o_torque_z   = r_torque_z;
    assign o_fluc_force = r_fluc_force;
    assign o_atom_pot   = r_atom_pot;
    assign o_total_pot  = r_total_pot;
    assign o_sweep_done = r_sweep_done;

`ifndef SYNTHESIS
    a_step_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= ST_DE2)
        else $error("sequencer step beyond schedule");

    a_stage2_in_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_d |-> (r_state == S_RUN || r_state == S_LAST))
        else $error("product stage active outside a run");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RUN && !o_in_ready))
        else $error("sequencer did not start after accepting an atom");

    a_sum_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_last) |=> (r_sum == '0 && o_out_valid && o_sweep_done))
        else $error("potential sum not cleared at end of sweep");
`endif

endmodule

### rtl/ufaf_mul.sv
// Shared fixed-point multiplier: registered 32x32 product, then a floor
// shift by FRAC_BITS and saturation to 32 bits. Depends on ufaf_pkg.
`timescale 1ns / 1ps

module ufaf_mul
    import ufaf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_p
);

    logic signed [63:0] r_prod;
    logic signed [63:0] prod_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // Arithmetic shift truncates toward minus infinity.
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign o_p     = sat32(prod_sh);

endmodule
